// ===== rtl/sobel_edge_magnitude_rgb_core_macros.svh =====
// Assertion macros used by the RTL core.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_CORE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, reset masked.
`define SEM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, reset masked.
`define SEM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define SEM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define SEM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/sem_pkg.sv =====
package sem_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int WID_W     = 11;
    localparam int HGT_W     = 16;
    localparam int ROW_W     = HGT_W + 2;
    localparam int PIX_W     = 8;
    localparam int NUM_CH    = 3;
    localparam int WORD_W    = PIX_W * NUM_CH;
    localparam int GRAD_W    = PIX_W + 4;
    // Above this squared magnitude the rounded root is at least 2^PIX_W.
    localparam int SAT_LIMIT = (2**PIX_W - 1) * (2**PIX_W);

    // Configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic             busy;
        logic [PIX_W-1:0] root;
    } sqrt_status_t;

endpackage

// ===== rtl/sem_sqrt_unit.sv =====
// Square and rounded-root unit for one channel.
module sem_sqrt_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [sem_pkg::GRAD_W-1:0]   grad_x,
    input  logic signed [sem_pkg::GRAD_W-1:0]   grad_y,
    output sem_pkg::sqrt_status_t               status
);
    import sem_pkg::*;

    localparam int MAG_W  = GRAD_W - 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int SQ_W   = PROD_W + 1;
    localparam int RAD_W  = 2 * PIX_W;
    localparam int CNT_W  = 4;
    localparam logic [CNT_W-1:0] STEP_SQ_X  = CNT_W'(0);
    localparam logic [CNT_W-1:0] STEP_SQ_Y  = CNT_W'(1);
    localparam logic [CNT_W-1:0] STEP_ROUND = CNT_W'(2 + PIX_W);

    logic                busy_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [MAG_W-1:0]    mag_a_reg, mag_b_reg;
    logic [SQ_W-1:0]     acc_reg;
    logic                sat_reg;
    logic [RAD_W:0]      rem_reg;
    logic [RAD_W-1:0]    res_reg, bit_reg;
    logic [PIX_W-1:0]    root_reg;

    logic [GRAD_W-1:0]   abs_x, abs_y;
    logic [MAG_W-1:0]    sq_op;
    logic [PROD_W-1:0]   sq_prod;
    logic [SQ_W-1:0]     mag2;
    logic [RAD_W:0]      trial;

    // Take magnitudes of the gradients
    assign abs_x = grad_x[GRAD_W-1] ? GRAD_W'(-grad_x) : GRAD_W'(grad_x);
    assign abs_y = grad_y[GRAD_W-1] ? GRAD_W'(-grad_y) : GRAD_W'(grad_y);

    // One multiplier squares x then y
    assign sq_op   = (cnt_reg == STEP_SQ_X) ? mag_a_reg : mag_b_reg;
    assign sq_prod = sq_op * sq_op;
    assign mag2    = acc_reg + SQ_W'(sq_prod);
    assign trial   = {1'b0, res_reg} + {1'b0, bit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= STEP_SQ_X;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == STEP_ROUND) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: square, sum, root digit steps, round
    always_ff @(posedge aclk) begin
        if (start) begin
            mag_a_reg <= abs_x[MAG_W-1:0];
            mag_b_reg <= abs_y[MAG_W-1:0];
        end else if (busy_reg) begin
            if (cnt_reg == STEP_SQ_X) begin
                acc_reg <= SQ_W'(sq_prod);
            end else if (cnt_reg == STEP_SQ_Y) begin
                sat_reg <= (mag2 > SQ_W'(SAT_LIMIT));
                rem_reg <= {1'b0, mag2[RAD_W-1:0]};
                res_reg <= '0;
                bit_reg <= RAD_W'(1) << (RAD_W - 2);
            end else if (cnt_reg == STEP_ROUND) begin
                if (sat_reg) begin
                    root_reg <= '1;
                end else begin
                    root_reg <= res_reg[PIX_W-1:0]
                              + PIX_W'(rem_reg > {1'b0, res_reg});
                end
            end else begin
                if (rem_reg >= trial) begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.root = root_reg;

endmodule

// ===== rtl/sobel_edge_magnitude_rgb_core.sv =====
// 3x3 Sobel edge magnitude on RGB pixels in raster order. Each word is a pixel
// (s_tuser = 0) or a flush tick (s_tuser = 1); send image_width+1 flush words
// after each frame, and the frame's final result carries m_tlast. A result
// lags its pixel by one row plus one pixel. A word that yields a result passes
// a line-store read, a window step, the per-channel square/root unit (two
// squarings on one multiplier, eight root digit steps, one rounding) and the
// load of the output register before the next word can be taken; a word
// without a result passes only the line-store read and the window step. A full
// output register that is not taken holds the block. Line stores need no
// clearing pass: frame borders mask stale entries.
`include "sobel_edge_magnitude_rgb_core_macros.svh"
module sobel_edge_magnitude_rgb_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sem_pkg::WORD_W-1:0]    s_tdata,   // pixel_red, pixel_green, pixel_blue
    input  logic [0:0]                    s_tuser,   // req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sem_pkg::WORD_W-1:0]    m_tdata,   // edge_red, edge_green, edge_blue
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_addr,
    input  logic [sem_pkg::HGT_W-1:0]     cfg_wdata
);
    import sem_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_SQRT = 3'b100
    } state_t;

    state_t              state_reg;
    logic [WID_W-1:0]    width_reg;
    logic [HGT_W-1:0]    height_reg;
    logic [ADDR_W-1:0]   col_reg, x_reg;
    logic [ROW_W-1:0]    row_reg, y_reg;
    logic [WORD_W-1:0]   pix_reg, top_rd_reg, mid_rd_reg;
    logic [WORD_W-1:0]   win_reg [6];
    logic                m_tvalid_reg, m_tlast_reg, last_reg;
    logic [WORD_W-1:0]   m_tdata_reg;

    logic [WORD_W-1:0]   upper_mem  [MAX_WIDTH];
    logic [WORD_W-1:0]   middle_mem [MAX_WIDTH];

    logic [WID_W-1:0]    w_eff;
    logic [ROW_W-1:0]    h_ext;
    logic [ADDR_W-1:0]   x_cur;
    logic [ROW_W-1:0]    y_cur;
    logic                s_fire, x0, have, emit, frame_end, out_load;
    logic [ROW_W-1:0]    orow;
    logic [WID_W-1:0]    ocol;
    logic                rv0, rv2, cv0, cv2;
    logic [WORD_W-1:0]   tap [3][3];
    logic [PIX_W-1:0]    val [NUM_CH][3][3];
    logic [PIX_W+1:0]    sum_l [NUM_CH], sum_r [NUM_CH], sum_t [NUM_CH], sum_b [NUM_CH];
    logic signed [GRAD_W-1:0] gx [NUM_CH], gy [NUM_CH];
    sqrt_status_t        unit_st [NUM_CH];
    logic                unit_start;

    // Clamp the configured size
    always_comb begin
        if (width_reg == '0) begin
            w_eff = WID_W'(1);
        end else if (width_reg > WID_W'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
    end
    assign h_ext = (height_reg == '0) ? ROW_W'(1) : ROW_W'(height_reg);

    // Start a new row if the column lies beyond the width
    assign x_cur = ({1'b0, col_reg} >= w_eff) ? '0 : col_reg;
    assign y_cur = ({1'b0, col_reg} >= w_eff) ? row_reg + ROW_W'(1) : row_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WID_W'(640);
            height_reg <= HGT_W'(480);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[WID_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Line stores: read on accept, write back during the window step
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            top_rd_reg <= upper_mem[x_cur];
        end
        if (state_reg == ST_LOAD) begin
            upper_mem[x_reg] <= mid_rd_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            mid_rd_reg <= middle_mem[x_cur];
        end
        if (state_reg == ST_LOAD) begin
            middle_mem[x_reg] <= pix_reg;
        end
    end

    // Capture the accepted word; flush counts as zero
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pix_reg <= s_tuser[0] ? '0 : s_tdata;
            x_reg   <= x_cur;
            y_reg   <= y_cur;
        end
    end

    // Output position and border masks
    assign x0   = (x_reg == '0);
    assign have = (y_reg >= ROW_W'(2)) || ((y_reg == ROW_W'(1)) && !x0);
    assign orow = x0 ? y_reg - ROW_W'(2) : y_reg - ROW_W'(1);
    assign ocol = x0 ? w_eff - WID_W'(1) : {1'b0, x_reg} - WID_W'(1);
    assign emit = have && (orow < h_ext);
    assign rv0  = (orow != '0);
    assign rv2  = (orow + ROW_W'(1)) < h_ext;
    assign cv0  = (ocol != '0);
    assign cv2  = !x0 && ((ocol + WID_W'(1)) < w_eff);
    assign frame_end = x0 && (y_reg >= h_ext + ROW_W'(1));

    // Assemble the window taps
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            tap[r][0] = win_reg[r];
            tap[r][1] = win_reg[3 + r];
        end
        tap[0][2] = x0 ? '0 : top_rd_reg;
        tap[1][2] = x0 ? '0 : mid_rd_reg;
        tap[2][2] = x0 ? '0 : pix_reg;
    end

    // Sobel sums per channel
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    val[ch][r][c] = tap[r][c][PIX_W*ch +: PIX_W];
                end
            end
            for (int c = 0; c < 3; c++) begin
                if (!rv0) val[ch][0][c] = '0;
                if (!rv2) val[ch][2][c] = '0;
            end
            for (int r = 0; r < 3; r++) begin
                if (!cv0) val[ch][r][0] = '0;
                if (!cv2) val[ch][r][2] = '0;
            end
            sum_l[ch] = (PIX_W+2)'(val[ch][0][0]) + ((PIX_W+2)'(val[ch][1][0]) << 1)
                      + (PIX_W+2)'(val[ch][2][0]);
            sum_r[ch] = (PIX_W+2)'(val[ch][0][2]) + ((PIX_W+2)'(val[ch][1][2]) << 1)
                      + (PIX_W+2)'(val[ch][2][2]);
            sum_t[ch] = (PIX_W+2)'(val[ch][0][0]) + ((PIX_W+2)'(val[ch][0][1]) << 1)
                      + (PIX_W+2)'(val[ch][0][2]);
            sum_b[ch] = (PIX_W+2)'(val[ch][2][0]) + ((PIX_W+2)'(val[ch][2][1]) << 1)
                      + (PIX_W+2)'(val[ch][2][2]);
            gx[ch] = signed'(GRAD_W'(sum_r[ch])) - signed'(GRAD_W'(sum_l[ch]));
            gy[ch] = signed'(GRAD_W'(sum_b[ch])) - signed'(GRAD_W'(sum_t[ch]));
        end
    end

    assign unit_start = (state_reg == ST_LOAD) && emit;

    genvar gc;
    generate
        for (gc = 0; gc < NUM_CH; gc++) begin : g_unit
            sem_sqrt_unit u_sqrt (
                .aclk    (aclk),
                .aresetn (aresetn),
                .start   (unit_start),
                .grad_x  (gx[gc]),
                .grad_y  (gy[gc]),
                .status  (unit_st[gc])
            );
        end
    endgenerate

    // Shift the window and advance the stream position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (state_reg == ST_LOAD) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_rd_reg;
            win_reg[4] <= mid_rd_reg;
            win_reg[5] <= pix_reg;
            if (frame_end) begin
                col_reg <= '0;
                row_reg <= '0;
            end else if (({1'b0, x_reg} + WID_W'(1)) >= w_eff) begin
                col_reg <= '0;
                row_reg <= y_reg + ROW_W'(1);
            end else begin
                col_reg <= x_reg + ADDR_W'(1);
                row_reg <= y_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD) begin
            last_reg <= (orow == h_ext - ROW_W'(1)) && (ocol == w_eff - WID_W'(1));
        end
    end

    // Sequencer
    assign out_load = (state_reg == ST_SQRT) && !unit_st[0].busy
                   && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: if (s_fire) state_reg <= ST_LOAD;
                ST_LOAD: state_reg <= emit ? ST_SQRT : ST_IDLE;
                ST_SQRT: if (out_load) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {unit_st[2].root, unit_st[1].root, unit_st[0].root};
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `SEM_ASSERT_NXT(a_fire_load, aclk, aresetn, s_fire, state_reg == ST_LOAD, "accept did not load")
    `SEM_ASSERT_IMP(a_load_free, aclk, aresetn, out_load, !m_tvalid_reg || m_tready, "output overrun")
    `SEM_ASSERT_IMP(a_units_sync, aclk, aresetn, 1'b1, (unit_st[0].busy == unit_st[1].busy) && (unit_st[0].busy == unit_st[2].busy), "units out of step")
    `SEM_ASSERT_NXT(a_start_busy, aclk, aresetn, unit_start, unit_st[0].busy && (state_reg == ST_SQRT), "unit did not start")

endmodule

// ===== test/sobel_edge_magnitude_rgb_core_test.sv =====
`timescale 1ns / 100ps
module sobel_edge_magnitude_rgb_core_test;
    import sem_pkg::*;

    localparam int  CLK_HALF    = 5;
    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  ITEM_GOAL   = 1400;
    localparam logic REQ_PIXEL  = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    typedef enum logic {ROW_SETUP, ROW_WORD} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        int                width;
        int                height;
        logic              req;
        logic [WORD_W-1:0] rgb;      // red in the low byte
        bit                typed;
        logic [WORD_W-1:0] edges;
        logic              last;
    } stim_row_t;

    typedef struct {
        logic [WORD_W-1:0] edges;
        logic              last;
    } edge_word_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [WORD_W-1:0]    s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [WORD_W-1:0]    m_tdata;
    logic                 m_tlast;
    logic                 cfg_we = 1'b0;
    logic [0:0]           cfg_addr = REG_IMAGE_WIDTH;
    logic [HGT_W-1:0]     cfg_wdata = '0;

    // predictor state
    logic [WORD_W-1:0] upper_row [MAX_WIDTH];
    logic [WORD_W-1:0] middle_row [MAX_WIDTH];
    logic [WORD_W-1:0] win_cols [6];
    int                col_pos;
    int                row_pos;
    int                cfg_w;
    int                cfg_h;

    edge_word_t edge_q[$];
    int         mismatches = 0;
    int         words_sent = 0;
    int         edges_seen = 0;
    int         frames_run = 0;
    int         cycles = 0;
    bit         calm = 1'b0;

    sobel_edge_magnitude_rgb_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // rounded magnitude of one channel over a masked 3x3 window
    function automatic logic [7:0] sobel_mag(input logic [8:0][WORD_W-1:0] taps,
                                             input bit [2:0] rv, input bit [2:0] cv,
                                             input int ch);
        int v [3][3];
        int gx, gy, m2, root;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                v[r][c] = (rv[r] && cv[c]) ? int'(taps[r*3+c][ch*8 +: 8]) : 0;
        gx = (v[0][2] - v[0][0]) + 2 * (v[1][2] - v[1][0]) + (v[2][2] - v[2][0]);
        gy = (v[2][0] + 2 * v[2][1] + v[2][2]) - (v[0][0] + 2 * v[0][1] + v[0][2]);
        m2 = gx * gx + gy * gy;
        root = 0;
        for (int b = 11; b >= 0; b--)
            if ((root | (1 << b)) * (root | (1 << b)) <= m2) root = root | (1 << b);
        if (m2 > root * root + root) root++;
        return (root > 255) ? 8'd255 : root[7:0];
    endfunction

    // advance the predictor by one word; push the edge word it yields, if any
    task automatic predict_word(input logic req, input logic [WORD_W-1:0] rgb,
                                input bit typed, input edge_word_t typed_word);
        int w, h, x, y, orow, ocol;
        logic [WORD_W-1:0] pix, top, mid;
        logic [8:0][WORD_W-1:0] taps;
        bit [2:0] rv, cv;
        edge_word_t ew;
        w = (cfg_w == 0) ? 1 : cfg_w;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = (cfg_h == 0) ? 1 : cfg_h;
        x = col_pos;
        y = row_pos;
        if (x >= w) begin
            x = 0;
            y++;
        end
        pix = (req == REQ_PIXEL) ? rgb : '0;
        top = upper_row[x];
        mid = middle_row[x];
        upper_row[x] = mid;
        middle_row[x] = pix;
        if (y >= 2 || (y == 1 && x >= 1)) begin
            orow = (x == 0) ? y - 2 : y - 1;
            ocol = (x == 0) ? w - 1 : x - 1;
            if (orow < h) begin
                for (int r = 0; r < 3; r++) begin
                    taps[r*3]   = win_cols[r];
                    taps[r*3+1] = win_cols[3+r];
                end
                taps[2] = (x == 0) ? '0 : top;
                taps[5] = (x == 0) ? '0 : mid;
                taps[8] = (x == 0) ? '0 : pix;
                rv = {orow + 1 < h, 1'b1, orow >= 1};
                cv = {(x != 0) && (ocol + 1 < w), 1'b1, ocol >= 1};
                for (int ch = 0; ch < 3; ch++)
                    ew.edges[ch*8 +: 8] = sobel_mag(taps, rv, cv, ch);
                ew.last = (orow == h - 1 && ocol == w - 1);
                edge_q.push_back(typed ? typed_word : ew);
            end
        end
        win_cols[0] = win_cols[3];
        win_cols[1] = win_cols[4];
        win_cols[2] = win_cols[5];
        win_cols[3] = top;
        win_cols[4] = mid;
        win_cols[5] = pix;
        if (x == 0 && y >= h + 1) begin
            x = 0;
            y = 0;
        end else if (x + 1 >= w) begin
            x = 0;
            y++;
        end else begin
            x++;
        end
        col_pos = x;
        row_pos = y;
    endtask

    // present one word, idling at random first; valid stays up for the next call
    task automatic send_word(input logic req, input logic [WORD_W-1:0] rgb,
                             input bit typed, input edge_word_t typed_word);
        while (!calm && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= rgb;
        do @(posedge aclk); while (!s_tready);
        predict_word(req, rgb, typed, typed_word);
        words_sent++;
    endtask

    // drop valid and hold until every expected word has arrived
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (edge_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // write both registers while the block is idle
    task automatic set_frame(input int w, input int h);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_IMAGE_WIDTH;
        cfg_wdata <= HGT_W'(w);
        @(posedge aclk);
        cfg_addr  <= REG_IMAGE_HEIGHT;
        cfg_wdata <= HGT_W'(h);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cfg_w = w & 11'h7FF;
        cfg_h = h & 16'hFFFF;
    endtask

    // one frame with random content, some flush words inside and pixels among the flushes
    task automatic random_frame(input int w, input int h);
        int ew;
        edge_word_t none;
        none = '{default: '0};
        ew = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
        set_frame(w, h);
        for (int i = 0; i < ew * ((h == 0) ? 1 : h); i++)
            send_word(($urandom_range(99) < 8) ? REQ_FLUSH : REQ_PIXEL,
                      WORD_W'($urandom), 1'b0, none);
        for (int i = 0; i <= ew; i++)
            send_word(($urandom_range(99) < 10) ? REQ_PIXEL : REQ_FLUSH,
                      WORD_W'($urandom), 1'b0, none);
        frames_run++;
    endtask

    // count cycles and stop a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycles, edge_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // randomize the result-side stall and check each accepted word
    always @(posedge aclk) begin
        edge_word_t exp_w;
        m_tready <= calm || ($urandom_range(99) >= 21);
        if (aresetn && m_tvalid && m_tready) begin
            edges_seen++;
            if (edge_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: edges=%h last=%b", m_tdata, m_tlast);
            end else begin
                exp_w = edge_q.pop_front();
                if (m_tdata[7:0] !== exp_w.edges[7:0] || m_tdata[15:8] !== exp_w.edges[15:8]
                    || m_tdata[23:16] !== exp_w.edges[23:16] || m_tlast !== exp_w.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at word %0d: r/g/b/last exp %0d/%0d/%0d/%b",
                                  " got %0d/%0d/%0d/%b"},
                                 edges_seen, exp_w.edges[7:0], exp_w.edges[15:8],
                                 exp_w.edges[23:16], exp_w.last, m_tdata[7:0],
                                 m_tdata[15:8], m_tdata[23:16], m_tlast);
                end
            end
        end
    end

    initial begin
        stim_row_t  plan[$];
        edge_word_t typed_word;
        edge_word_t none;
        int         w, h;
        none = '{default: '0};
        for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        for (int i = 0; i < 6; i++) win_cols[i] = '0;
        col_pos = 0;
        row_pos = 0;
        cfg_w = 640;
        cfg_h = 480;

        // directed part: setup rows, then words; typed results where obvious
        plan = '{
            '{ROW_SETUP, 1, 1, REQ_PIXEL, 24'h0, 0, 24'h0, 0},
            '{ROW_WORD, 0, 0, REQ_PIXEL, 24'hFFFFFF, 0, 24'h0, 0},
            '{ROW_WORD, 0, 0, REQ_FLUSH, 24'hFFFFFF, 0, 24'h0, 0},
            '{ROW_WORD, 0, 0, REQ_FLUSH, 24'h000000, 1, 24'h0, 1},
            '{ROW_SETUP, 2, 2, REQ_PIXEL, 24'h0, 0, 24'h0, 0},
            '{ROW_WORD, 0, 0, REQ_PIXEL, 24'hFFFFFF, 0, 24'h0, 0},
            '{ROW_WORD, 0, 0, REQ_PIXEL, 24'hFFFFFF, 0, 24'h0, 0},
            '{ROW_WORD, 0, 0, REQ_PIXEL, 24'hFFFFFF, 0, 24'h0, 0},
            '{ROW_WORD, 0, 0, REQ_PIXEL, 24'hFFFFFF, 1, 24'hFFFFFF, 0},
            '{ROW_WORD, 0, 0, REQ_FLUSH, 24'h000000, 1, 24'hFFFFFF, 0},
            '{ROW_WORD, 0, 0, REQ_FLUSH, 24'h000000, 1, 24'hFFFFFF, 0},
            '{ROW_WORD, 0, 0, REQ_FLUSH, 24'h000000, 1, 24'hFFFFFF, 1},
            '{ROW_SETUP, 3, 2, REQ_PIXEL, 24'h0, 0, 24'h0, 0},
            '{ROW_WORD, 0, 0, REQ_PIXEL, 24'h000000, 0, 24'h0, 0},
            '{ROW_WORD, 0, 0, REQ_PIXEL, 24'hFFFFFF, 0, 24'h0, 0},
            '{ROW_WORD, 0, 0, REQ_PIXEL, 24'h0000FF, 0, 24'h0, 0},
            '{ROW_WORD, 0, 0, REQ_FLUSH, 24'hFFFFFF, 0, 24'h0, 0},
            '{ROW_WORD, 0, 0, REQ_PIXEL, 24'h00FF00, 0, 24'h0, 0},
            '{ROW_WORD, 0, 0, REQ_PIXEL, 24'hFF0000, 0, 24'h0, 0},
            '{ROW_WORD, 0, 0, REQ_FLUSH, 24'h0, 0, 24'h0, 0},
            '{ROW_WORD, 0, 0, REQ_FLUSH, 24'h0, 0, 24'h0, 0},
            '{ROW_WORD, 0, 0, REQ_FLUSH, 24'h0, 0, 24'h0, 0},
            '{ROW_WORD, 0, 0, REQ_FLUSH, 24'h0, 0, 24'h0, 0},
            '{ROW_SETUP, 0, 0, REQ_PIXEL, 24'h0, 0, 24'h0, 0},
            '{ROW_WORD, 0, 0, REQ_PIXEL, 24'h5A5A5A, 0, 24'h0, 0},
            '{ROW_WORD, 0, 0, REQ_FLUSH, 24'h0, 0, 24'h0, 0},
            '{ROW_WORD, 0, 0, REQ_FLUSH, 24'h0, 1, 24'h0, 1}
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // tallest frame setting is written but overwritten before any pixel
        set_frame(1, 65535);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_SETUP) begin
                set_frame(plan[i].width, plan[i].height);
            end else begin
                typed_word.edges = plan[i].edges;
                typed_word.last  = plan[i].last;
                send_word(plan[i].req, plan[i].rgb, plan[i].typed, typed_word);
            end
        end

        // random frames, mostly small, a calm stretch in the middle
        while (words_sent < ITEM_GOAL) begin
            calm = (frames_run >= 12 && frames_run < 20);
            w = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
            h = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
            random_frame(w, h);
        end
        calm = 1'b0;

        wait_idle();
        repeat (40) @(posedge aclk);
        $display("ran %0d frames, %0d words in, %0d edge words checked", frames_run + 4,
                 words_sent, edges_seen);
        $display("widths 0..64, heights 0..24, flush words mixed into frames");
        if (mismatches == 0 && edge_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d words missing", mismatches, edge_q.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
